[hdl/dsi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsi_pkg
// Codes and helpers for the two-axis drive safety interlock.
// ----------------------------------------------------------------------------
package dsi_pkg;

  localparam int GenWidth = 32;
  localparam int CmdWidth = 32;

  typedef enum logic [2:0] {
    ST_NORMAL   = 3'd0,
    ST_SHUTDOWN = 3'd1,
    ST_STARTUP  = 3'd2,
    ST_ESTOP    = 3'd3,
    ST_BUS      = 3'd4,
    ST_FAULT    = 3'd5,
    ST_ZERO     = 3'd6
  } safety_t;

  typedef enum logic [2:0] {
    ACT_DISABLE_V = 3'd0,
    ACT_HOLD      = 3'd1,
    ACT_QSTOP     = 3'd2,
    ACT_FRESET    = 3'd3,
    ACT_SHUTDOWN  = 3'd4,
    ACT_SWITCH_ON = 3'd5,
    ACT_ENABLE_OP = 3'd6,
    ACT_TARGET    = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    AX_DISABLED = 3'd0,
    AX_READY    = 3'd1,
    AX_SWON     = 3'd2,
    AX_ENABLED  = 3'd3,
    AX_FAULT    = 3'd4
  } axis_t;

  // both axes report the same named state
  function automatic logic axes_are(input logic [5:0] axes, input axis_t code);
    return (axes[2:0] == code) && (axes[5:3] == code);
  endfunction

endpackage

[hdl/drive_safety_interlock.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_safety_interlock
// Fail-closed two-axis drive interlock: one safety decision per snapshot word.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  input   | in_valid/in_ready  | snapshot flags, axis states, command, generations
//  output  | out_valid/out_ready| safety state, action, target, authorization, count
//
//  one word per cycle sustained while the output is not stalled; each accepted word
//  goes through the input register, then decision logic into the result register.
//  the priority chain and both 32-bit generation compares sit in that one logic stage.
//  rst clears valids, counter and generations and sets the re-arm flag.
//  a stalled output holds the result register; the input register still fills
//  once, so one new word is taken while a result waits.
module drive_safety_interlock (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        shutdown_request,
  input  logic        snapshot_coherent,
  input  logic [1:0]  estop_status,
  input  logic [1:0]  bus_status,
  input  logic [4:0]  link_health,
  input  logic        fault_active,
  input  logic [5:0]  axis_states,
  input  logic [1:0]  reset_request,
  input  logic [1:0]  selection,
  input  logic [31:0] command_target,
  input  logic [31:0] reset_generation,
  input  logic [31:0] auth_generation,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  safety_state,
  output logic [2:0]  drive_action,
  output logic [31:0] passed_target,
  output logic [31:0] granted_authorization,
  output logic [31:0] decision_count,
  output logic        motion_granted,
  output logic        reset_eligible
);

  // input register
  logic        s1_valid;
  logic        s1_shutdown;
  logic        s1_coherent;
  logic [1:0]  s1_estop;
  logic [1:0]  s1_bus;
  logic [4:0]  s1_links;
  logic        s1_dfault;
  logic [5:0]  s1_axes;
  logic [1:0]  s1_rreq;
  logic [1:0]  s1_sel;
  logic [dsi_pkg::CmdWidth-1:0] s1_cmd;
  logic [dsi_pkg::GenWidth-1:0] s1_rgen;
  logic [dsi_pkg::GenWidth-1:0] s1_agen;

  // decision state
  logic [31:0] decision_counter;
  logic        rearm_needed;
  logic [dsi_pkg::GenWidth-1:0] last_reset_gen;
  logic [dsi_pkg::GenWidth-1:0] last_auth_gen;

  logic        rearm_needed_next;
  logic [dsi_pkg::GenWidth-1:0] last_reset_gen_next;
  logic [dsi_pkg::GenWidth-1:0] last_auth_gen_next;

  dsi_pkg::safety_t st_d;
  dsi_pkg::action_t act_d;
  logic [dsi_pkg::CmdWidth-1:0] tgt_d;
  logic [dsi_pkg::GenWidth-1:0] auth_d;
  logic        motion_d;
  logic        elig_d;

  logic advance;
  logic bus_ok;
  logic links_ok;
  logic fresh_auth;
  logic newer_reset;
  logic cmd_zero;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_shutdown <= shutdown_request;
      s1_coherent <= snapshot_coherent;
      s1_estop    <= estop_status;
      s1_bus      <= bus_status;
      s1_links    <= link_health;
      s1_dfault   <= fault_active;
      s1_axes     <= axis_states;
      s1_rreq     <= reset_request;
      s1_sel      <= selection;
      s1_cmd      <= command_target;
      s1_rgen     <= reset_generation;
      s1_agen     <= auth_generation;
    end
  end

  assign bus_ok      = s1_bus[0] && !s1_bus[1];
  assign links_ok    = &s1_links;
  assign fresh_auth  = s1_agen > last_auth_gen;
  assign newer_reset = s1_rgen > last_reset_gen;
  assign cmd_zero    = (s1_cmd == '0);

  // strict priority chain
  always_comb begin
    st_d                = dsi_pkg::ST_ZERO;
    act_d               = dsi_pkg::ACT_QSTOP;
    tgt_d               = '0;
    auth_d              = '0;
    motion_d            = 1'b0;
    elig_d              = 1'b0;
    rearm_needed_next   = 1'b1;
    last_reset_gen_next = last_reset_gen;
    last_auth_gen_next  = last_auth_gen;
    if (s1_shutdown) begin
      st_d  = dsi_pkg::ST_SHUTDOWN;
      act_d = dsi_pkg::ACT_DISABLE_V;
    end else if (!s1_coherent) begin
      st_d  = dsi_pkg::ST_STARTUP;
      act_d = dsi_pkg::ACT_HOLD;
    end else if (!s1_estop[0] || s1_estop[1]) begin
      st_d  = dsi_pkg::ST_ESTOP;
      act_d = dsi_pkg::ACT_DISABLE_V;
    end else if (!(bus_ok && links_ok)) begin
      st_d  = dsi_pkg::ST_BUS;
      act_d = bus_ok ? dsi_pkg::ACT_QSTOP : dsi_pkg::ACT_HOLD;
    end else if (s1_dfault || dsi_pkg::axes_are(s1_axes, dsi_pkg::AX_FAULT)) begin
      st_d = dsi_pkg::ST_FAULT;
      if (s1_rreq[0] && s1_rreq[1] && cmd_zero && s1_sel[0] && newer_reset &&
          dsi_pkg::axes_are(s1_axes, dsi_pkg::AX_FAULT)) begin
        act_d               = dsi_pkg::ACT_FRESET;
        auth_d              = s1_agen;
        elig_d              = 1'b1;
        last_reset_gen_next = s1_rgen;
      end
    end else if (!s1_sel[0] || !s1_sel[1]) begin
      st_d = dsi_pkg::ST_ZERO;
    end else if (rearm_needed && !fresh_auth) begin
      rearm_needed_next = rearm_needed;
    end else if (dsi_pkg::axes_are(s1_axes, dsi_pkg::AX_DISABLED)) begin
      act_d             = dsi_pkg::ACT_SHUTDOWN;
      rearm_needed_next = rearm_needed;
    end else if (dsi_pkg::axes_are(s1_axes, dsi_pkg::AX_READY)) begin
      act_d             = dsi_pkg::ACT_SWITCH_ON;
      rearm_needed_next = rearm_needed;
    end else if (dsi_pkg::axes_are(s1_axes, dsi_pkg::AX_SWON)) begin
      act_d             = dsi_pkg::ACT_ENABLE_OP;
      rearm_needed_next = rearm_needed;
    end else if (dsi_pkg::axes_are(s1_axes, dsi_pkg::AX_ENABLED)) begin
      st_d              = dsi_pkg::ST_NORMAL;
      act_d             = cmd_zero ? dsi_pkg::ACT_ENABLE_OP : dsi_pkg::ACT_TARGET;
      tgt_d             = s1_cmd;
      auth_d            = s1_agen;
      motion_d          = !cmd_zero;
      rearm_needed_next = 1'b0;
      if (fresh_auth) begin
        last_auth_gen_next = s1_agen;
      end
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      decision_counter <= '0;
      rearm_needed     <= 1'b1;
      last_reset_gen   <= '0;
      last_auth_gen    <= '0;
    end else begin
      if (advance) begin
        out_valid        <= 1'b1;
        decision_counter <= decision_counter + 32'd1;
        rearm_needed     <= rearm_needed_next;
        last_reset_gen   <= last_reset_gen_next;
        last_auth_gen    <= last_auth_gen_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      safety_state          <= st_d;
      drive_action          <= act_d;
      passed_target         <= tgt_d;
      granted_authorization <= auth_d;
      decision_count        <= decision_counter + 32'd1;
      motion_granted        <= motion_d;
      reset_eligible        <= elig_d;
    end
  end

  a_motion_only_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid && (motion_granted || passed_target != '0) |->
      safety_state == dsi_pkg::ST_NORMAL)
    else $error("motion granted outside normal state");

  a_reset_grant_action: assert property (@(posedge clk) disable iff (rst)
    out_valid && reset_eligible |->
      drive_action == dsi_pkg::ACT_FRESET && safety_state == dsi_pkg::ST_FAULT)
    else $error("reset grant without fault reset action");

  a_normal_clears_rearm: assert property (@(posedge clk) disable iff (rst)
    advance && st_d == dsi_pkg::ST_NORMAL |=> !rearm_needed)
    else $error("re-arm flag not cleared after normal decision");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> decision_counter == $past(decision_counter) + 32'd1
      && decision_count == decision_counter)
    else $error("decision counter out of step");

  a_reset_gen_monotonic: assert property (@(posedge clk) disable iff (rst)
    advance && last_reset_gen_next != last_reset_gen |-> elig_d)
    else $error("reset generation moved without a grant");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-axis drive safety interlock. Snapshot words
// go in through the valid/ready input channel. An internal predictor tracks
// the decision counter, the re-arm flag and both generation registers, and it
// queues one expected decision per accepted word. Each decision that comes out
// is checked field by field against the oldest queued one. A short directed
// sweep walks the priority chain. Random traffic follows: mostly healthy
// ladder and fault-reset sequences, plus broken and pure noise words. The run
// uses three handshake phases: heavy receiver stalls, heavy sender gaps, then none.
// ----------------------------------------------------------------------------
module tb;

  localparam int PhaseWords   = 600;
  localparam int QuietLimit   = 5000;
  localparam int SettleCycles = 10;

  typedef struct packed {
    logic        shutdown;
    logic        coherent;
    logic [1:0]  estop;
    logic [1:0]  bus;
    logic [4:0]  links;
    logic        fault;
    logic [5:0]  axes;
    logic [1:0]  rst_req;
    logic [1:0]  sel;
    logic [31:0] cmd;
    logic [31:0] rgen;
    logic [31:0] agen;
  } snapshot_t;

  typedef struct packed {
    dsi_pkg::safety_t state;
    dsi_pkg::action_t action;
    logic [31:0]      target;
    logic [31:0]      auth;
    logic [31:0]      count;
    logic             motion;
    logic             eligible;
  } decision_t;

  class decision_tracker;
    logic [31:0] decisions;
    logic        rearm;
    logic [31:0] last_rgen;
    logic [31:0] last_agen;
    decision_t   pending_decisions[$];
    int          errors;
    int          words;
    int          results;
    int          motions;
    int          resets_granted;

    function new();
      decisions      = '0;
      rearm          = 1'b1;
      last_rgen      = '0;
      last_agen      = '0;
      errors         = 0;
      words          = 0;
      results        = 0;
      motions        = 0;
      resets_granted = 0;
    endfunction

    // priority chain for one snapshot; updates the interlock state
    function decision_t decide(snapshot_t s);
      decision_t  d;
      logic [2:0] lo;
      logic [2:0] hi;
      logic       bus_ok;
      logic       fresh;
      lo        = s.axes[2:0];
      hi        = s.axes[5:3];
      bus_ok    = s.bus[0] && !s.bus[1];
      decisions = decisions + 32'd1;
      d         = '0;
      d.count   = decisions;
      d.state   = dsi_pkg::ST_ZERO;
      d.action  = dsi_pkg::ACT_QSTOP;
      if (s.shutdown) begin
        rearm    = 1'b1;
        d.state  = dsi_pkg::ST_SHUTDOWN;
        d.action = dsi_pkg::ACT_DISABLE_V;
      end else if (!s.coherent) begin
        rearm    = 1'b1;
        d.state  = dsi_pkg::ST_STARTUP;
        d.action = dsi_pkg::ACT_HOLD;
      end else if (!s.estop[0] || s.estop[1]) begin
        rearm    = 1'b1;
        d.state  = dsi_pkg::ST_ESTOP;
        d.action = dsi_pkg::ACT_DISABLE_V;
      end else if (!bus_ok || s.links != 5'h1f) begin
        rearm    = 1'b1;
        d.state  = dsi_pkg::ST_BUS;
        d.action = bus_ok ? dsi_pkg::ACT_QSTOP : dsi_pkg::ACT_HOLD;
      end else if (s.fault || (lo == dsi_pkg::AX_FAULT && hi == dsi_pkg::AX_FAULT)) begin
        rearm   = 1'b1;
        d.state = dsi_pkg::ST_FAULT;
        if (s.rst_req == 2'b11 && s.cmd == '0 && s.sel[0] && s.rgen > last_rgen &&
            lo == dsi_pkg::AX_FAULT && hi == dsi_pkg::AX_FAULT) begin
          last_rgen  = s.rgen;
          d.action   = dsi_pkg::ACT_FRESET;
          d.auth     = s.agen;
          d.eligible = 1'b1;
          resets_granted++;
        end
      end else if (s.sel != 2'b11) begin
        rearm = 1'b1;
      end else begin
        fresh = s.agen > last_agen;
        // an inhibited interlock stays in zero hold until a newer authorization
        if (!rearm || fresh) begin
          if (lo == dsi_pkg::AX_DISABLED && hi == dsi_pkg::AX_DISABLED) begin
            d.action = dsi_pkg::ACT_SHUTDOWN;
          end else if (lo == dsi_pkg::AX_READY && hi == dsi_pkg::AX_READY) begin
            d.action = dsi_pkg::ACT_SWITCH_ON;
          end else if (lo == dsi_pkg::AX_SWON && hi == dsi_pkg::AX_SWON) begin
            d.action = dsi_pkg::ACT_ENABLE_OP;
          end else if (!(lo == dsi_pkg::AX_ENABLED && hi == dsi_pkg::AX_ENABLED)) begin
            rearm = 1'b1;
          end else begin
            if (fresh) last_agen = s.agen;
            rearm    = 1'b0;
            d.state  = dsi_pkg::ST_NORMAL;
            d.target = s.cmd;
            d.auth   = s.agen;
            d.motion = s.cmd != '0;
            d.action = d.motion ? dsi_pkg::ACT_TARGET : dsi_pkg::ACT_ENABLE_OP;
            if (d.motion) motions++;
          end
        end
      end
      return d;
    endfunction

    function void note_input(snapshot_t s);
      pending_decisions.push_back(decide(s));
      words++;
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(decision_t got);
      decision_t want;
      results++;
      if (pending_decisions.size() == 0) begin
        errors++;
        $display("%0t: unexpected decision, expected none actual %h", $time, got);
      end else begin
        want = pending_decisions.pop_front();
        compare("safety_state", 32'(want.state), 32'(got.state));
        compare("drive_action", 32'(want.action), 32'(got.action));
        compare("passed_target", want.target, got.target);
        compare("granted_authorization", want.auth, got.auth);
        compare("decision_count", want.count, got.count);
        compare("motion_granted", 32'(want.motion), 32'(got.motion));
        compare("reset_eligible", 32'(want.eligible), 32'(got.eligible));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        shutdown_request;
  logic        snapshot_coherent;
  logic [1:0]  estop_status;
  logic [1:0]  bus_status;
  logic [4:0]  link_health;
  logic        fault_active;
  logic [5:0]  axis_states;
  logic [1:0]  reset_request;
  logic [1:0]  selection;
  logic [31:0] command_target;
  logic [31:0] reset_generation;
  logic [31:0] auth_generation;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  safety_state;
  logic [2:0]  drive_action;
  logic [31:0] passed_target;
  logic [31:0] granted_authorization;
  logic [31:0] decision_count;
  logic        motion_granted;
  logic        reset_eligible;

  decision_tracker sb;
  int              send_gap_pct   = 0;
  int              recv_stall_pct = 0;
  int              quiet          = 0;
  snapshot_t       seen_word;
  decision_t       seen_decision;

  drive_safety_interlock i_dut (
    .clk                   (clk),
    .rst                   (rst),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .shutdown_request      (shutdown_request),
    .snapshot_coherent     (snapshot_coherent),
    .estop_status          (estop_status),
    .bus_status            (bus_status),
    .link_health           (link_health),
    .fault_active          (fault_active),
    .axis_states           (axis_states),
    .reset_request         (reset_request),
    .selection             (selection),
    .command_target        (command_target),
    .reset_generation      (reset_generation),
    .auth_generation       (auth_generation),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .safety_state          (safety_state),
    .drive_action          (drive_action),
    .passed_target         (passed_target),
    .granted_authorization (granted_authorization),
    .decision_count        (decision_count),
    .motion_granted        (motion_granted),
    .reset_eligible        (reset_eligible)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= $urandom_range(99) >= recv_stall_pct;
  end

  // word in first, so a same-edge decision always finds its expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen_word.shutdown = shutdown_request;
        seen_word.coherent = snapshot_coherent;
        seen_word.estop    = estop_status;
        seen_word.bus      = bus_status;
        seen_word.links    = link_health;
        seen_word.fault    = fault_active;
        seen_word.axes     = axis_states;
        seen_word.rst_req  = reset_request;
        seen_word.sel      = selection;
        seen_word.cmd      = command_target;
        seen_word.rgen     = reset_generation;
        seen_word.agen     = auth_generation;
        sb.note_input(seen_word);
      end
      if (out_valid && out_ready) begin
        seen_decision.state    = dsi_pkg::safety_t'(safety_state);
        seen_decision.action   = dsi_pkg::action_t'(drive_action);
        seen_decision.target   = passed_target;
        seen_decision.auth     = granted_authorization;
        seen_decision.count    = decision_count;
        seen_decision.motion   = motion_granted;
        seen_decision.eligible = reset_eligible;
        sb.check_result(seen_decision);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic snapshot_t healthy();
    snapshot_t w;
    w          = '0;
    w.coherent = 1'b1;
    w.estop    = 2'b01;
    w.bus      = 2'b01;
    w.links    = 5'h1f;
    w.axes     = {dsi_pkg::AX_ENABLED, dsi_pkg::AX_ENABLED};
    w.sel      = 2'b11;
    return w;
  endfunction

  task automatic send_word(input snapshot_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    shutdown_request  <= w.shutdown;
    snapshot_coherent <= w.coherent;
    estop_status      <= w.estop;
    bus_status        <= w.bus;
    link_health       <= w.links;
    fault_active      <= w.fault;
    axis_states       <= w.axes;
    reset_request     <= w.rst_req;
    selection         <= w.sel;
    command_target    <= w.cmd;
    reset_generation  <= w.rgen;
    auth_generation   <= w.agen;
    in_valid          <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the sender until every queued decision has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending_decisions.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    snapshot_t    w;
    logic [127:0] noise;
    logic [31:0]  hi_auth;
    logic [31:0]  hi_rst;
    logic [2:0]   ladder;
    int           r;
    int           k;
    sb = new();
    rst               <= 1'b1;
    in_valid          <= 1'b0;
    out_ready         <= 1'b0;
    shutdown_request  <= 1'b0;
    snapshot_coherent <= 1'b0;
    estop_status      <= '0;
    bus_status        <= '0;
    link_health       <= '0;
    fault_active      <= 1'b0;
    axis_states       <= '0;
    reset_request     <= '0;
    selection         <= '0;
    command_target    <= '0;
    reset_generation  <= '0;
    auth_generation   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct   = 17;
    recv_stall_pct = 53;

    // directed walk down the priority chain
    w = '0;
    send_word(w);
    w = '1;
    send_word(w);
    w = healthy(); w.estop = 2'b00;
    send_word(w);
    w = healthy(); w.estop = 2'b11;
    send_word(w);
    w = healthy(); w.bus = 2'b00;
    send_word(w);
    w = healthy(); w.bus = 2'b11;
    send_word(w);
    w = healthy(); w.links = 5'h1e;
    send_word(w);
    // fault reset: zero generation, nonzero command, granted, repeated
    w = healthy(); w.fault = 1'b1; w.rst_req = 2'b11;
    w.axes = {dsi_pkg::AX_FAULT, dsi_pkg::AX_FAULT};
    send_word(w);
    w.rgen = 32'd5; w.cmd = 32'd1;
    send_word(w);
    w.cmd = '0; w.agen = '1;
    send_word(w);
    send_word(w);
    w.axes = {dsi_pkg::AX_FAULT, dsi_pkg::AX_ENABLED}; w.rgen = 32'd6;
    send_word(w);
    w = healthy(); w.rst_req = 2'b01; w.rgen = 32'd7;
    w.axes = {dsi_pkg::AX_FAULT, dsi_pkg::AX_FAULT};
    send_word(w);
    w = healthy(); w.sel = 2'b10;
    send_word(w);
    w.sel = 2'b01;
    send_word(w);
    // re-arm ladder
    w = healthy();
    send_word(w);
    w.axes = {dsi_pkg::AX_DISABLED, dsi_pkg::AX_DISABLED}; w.agen = 32'd1;
    send_word(w);
    w.axes = {dsi_pkg::AX_READY, dsi_pkg::AX_READY};
    send_word(w);
    w.axes = {dsi_pkg::AX_SWON, dsi_pkg::AX_SWON};
    send_word(w);
    w.axes = {dsi_pkg::AX_ENABLED, dsi_pkg::AX_ENABLED};
    send_word(w);
    w.cmd = 32'h1234_5678;
    send_word(w);
    // unnamed axis codes five, six and seven
    w.axes = 6'o76;
    send_word(w);
    w.axes = {dsi_pkg::AX_ENABLED, dsi_pkg::AX_ENABLED};
    send_word(w);
    w.axes = 6'o53; w.agen = 32'h8000_0001;
    send_word(w);
    // generations above the sign bit must compare as newer
    w.axes = {dsi_pkg::AX_ENABLED, dsi_pkg::AX_ENABLED}; w.cmd = '1;
    send_word(w);
    w = healthy(); w.rst_req = 2'b11;
    w.axes = {dsi_pkg::AX_FAULT, dsi_pkg::AX_FAULT};
    w.rgen = 32'h8000_0000;
    send_word(w);
    drain();

    hi_auth = 32'h8000_0001;
    hi_rst  = 32'h8000_0000;
    ladder  = dsi_pkg::AX_DISABLED;
    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct   = (phase == 0) ? 17 : (phase == 1) ? 53 : 0;
      recv_stall_pct = (phase == 0) ? 53 : (phase == 1) ? 17 : 0;
      for (int i = 0; i < PhaseWords; i++) begin
        r = $urandom_range(99);
        w = healthy();
        if ($urandom_range(3) == 0)
          ladder = (ladder >= dsi_pkg::AX_ENABLED) ? dsi_pkg::AX_DISABLED : ladder + 3'd1;
        w.axes = {ladder, ladder};
        if ($urandom_range(11) == 0) w.axes = 6'($urandom_range(63));
        w.cmd = ($urandom_range(3) == 0) ? '0 : $urandom();
        k = $urandom_range(5);
        if (k < 2) begin
          hi_auth = hi_auth + $urandom_range(1, 300);
          w.agen  = hi_auth;
        end else if (k < 4) begin
          w.agen = hi_auth;
        end else if (k == 4) begin
          w.agen = hi_auth - $urandom_range(1, 300);
        end
        w.rst_req = 2'($urandom_range(3));
        w.rgen    = hi_rst;
        if ($urandom_range(9) == 0) w.sel = 2'($urandom_range(3));
        if (r >= 55 && r < 72) begin
          // fault reset attempt
          w.axes = {dsi_pkg::AX_FAULT, dsi_pkg::AX_FAULT};
          if ($urandom_range(3) == 0) w.axes = 6'($urandom_range(63));
          w.fault   = 1'($urandom_range(1));
          w.rst_req = ($urandom_range(4) == 0) ? 2'($urandom_range(3)) : 2'b11;
          w.cmd     = ($urandom_range(4) == 0) ? $urandom() : '0;
          w.agen    = $urandom();
          if ($urandom_range(1)) hi_rst = hi_rst + $urandom_range(1, 300);
          w.rgen = hi_rst;
          if ($urandom_range(2) == 0) ladder = dsi_pkg::AX_DISABLED;
        end else if (r >= 72 && r < 88) begin
          // one broken field in an otherwise healthy word
          case ($urandom_range(6))
            0: w.shutdown = 1'b1;
            1: w.coherent = 1'b0;
            2: w.estop    = ($urandom_range(1)) ? 2'b00 : 2'($urandom_range(2, 3));
            3: w.bus      = ($urandom_range(1)) ? 2'b00 : 2'($urandom_range(2, 3));
            4: w.links    = 5'($urandom_range(30));
            5: w.fault    = 1'b1;
            default: w.sel = 2'($urandom_range(2));
          endcase
        end else if (r >= 88) begin
          noise = {$urandom(), $urandom(), $urandom(), $urandom()};
          w     = noise[$bits(snapshot_t)-1:0];
        end
        send_word(w);
      end
      drain();
    end

    repeat (SettleCycles) @(posedge clk);
    $display("covered %0d snapshot words, %0d decisions", sb.words, sb.results);
    $display("gapped, stalled and back-to-back traffic; %0d motions, %0d fault resets",
             sb.motions, sb.resets_granted);
    if (sb.errors == 0 && sb.pending_decisions.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/dsi_pkg.sv
hdl/drive_safety_interlock.sv
bench/tb.sv
